@@ hw/rtl/cmirq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package cmirq_pkg;

  localparam int RAM_DEPTH = 128;
  localparam int RAM_AW    = $clog2(RAM_DEPTH);

  localparam int MOD_STEPS = 8;
  localparam int MOD_CW    = $clog2(MOD_STEPS + 1);

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_CHR_PAGE_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_INCREMENT = 1'd1;

  localparam logic [8:0]  CHR_PAGE_COUNT_RST = 9'd256;
  localparam logic [9:0]  TICK_INCREMENT_RST = 10'd113;
  localparam logic [15:0] IRQ_LIMIT          = 16'h7FFF;
  localparam logic [7:0]  NT_INTERNAL_MIN    = 8'hE0;

  localparam logic [1:0] FUNC_READ  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;

  localparam logic [1:0] MAP_NONE    = 2'd0;
  localparam logic [1:0] MAP_PATTERN = 2'd1;
  localparam logic [1:0] MAP_NAME    = 2'd2;
  localparam logic [1:0] MAP_PROGRAM = 2'd3;

  localparam logic [4:0] REG_RAM      = 5'h09;
  localparam logic [4:0] REG_CNT_LO   = 5'h0A;
  localparam logic [4:0] REG_CNT_HI   = 5'h0B;
  localparam logic [4:0] REG_PAT_LO   = 5'h10;
  localparam logic [4:0] REG_PAT_HI   = 5'h17;
  localparam logic [4:0] REG_NT_LO    = 5'h18;
  localparam logic [4:0] REG_NT_HI    = 5'h1B;
  localparam logic [4:0] REG_PRG_LO   = 5'h1C;
  localparam logic [4:0] REG_PRG_HI   = 5'h1E;
  localparam logic [4:0] REG_POINTER  = 5'h1F;
  localparam logic [2:0] PRG_SLOT_OFS = 3'd4;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [RAM_AW-1:0] addr;
    logic [7:0]        wdata;
  } ram_req_t;

  typedef struct packed {
    logic       start;
    logic [7:0] dividend;
    logic [8:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] rem;
  } mod_rsp_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_fire;
    logic [1:0] map_kind;
    logic [2:0] map_slot;
    logic [7:0] map_page;
    logic       map_internal;
  } result_t;

endpackage

`default_nettype wire

@@ hw/rtl/cmirq_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cmirq_ram
  import cmirq_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire ram_req_t req,
  output logic [7:0]    rdata
);

  logic [7:0]           mem [RAM_DEPTH];
  logic [RAM_DEPTH-1:0] vld_r;
  logic [7:0]           mem_rd_r;
  logic                 vld_rd_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.re) begin
      mem_rd_r <= mem[req.addr];
    end
  end

  // Entries never written since reset read as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      vld_rd_r <= 1'b0;
    end else begin
      if (req.we) begin
        vld_r[req.addr] <= 1'b1;
      end
      if (req.re) begin
        vld_rd_r <= vld_r[req.addr];
      end
    end
  end

  assign rdata = vld_rd_r ? mem_rd_r : 8'd0;

endmodule

`default_nettype wire

@@ hw/rtl/cmirq_mod.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cmirq_mod
  import cmirq_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire mod_req_t req,
  output mod_rsp_t      rsp
);

  logic [7:0]        rem_r, rem_nxt;
  logic [7:0]        dvd_r, dvd_nxt;
  logic [8:0]        div_r, div_nxt;
  logic [MOD_CW-1:0] cnt_r, cnt_nxt;
  logic              done_r, done_nxt;
  logic [8:0]        trial;

  // One restoring step per cycle: shift in the next dividend bit and
  // subtract the divisor when it fits.
  always_comb begin
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    div_nxt  = div_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    trial    = {rem_r, dvd_r[7]};
    if (req.start) begin
      rem_nxt = 8'd0;
      dvd_nxt = req.dividend;
      div_nxt = req.divisor;
      cnt_nxt = MOD_CW'(MOD_STEPS);
    end else if (cnt_r != '0) begin
      if (trial >= div_r) begin
        rem_nxt = 8'(trial - div_r);
      end else begin
        rem_nxt = trial[7:0];
      end
      dvd_nxt = {dvd_r[6:0], 1'b0};
      cnt_nxt = cnt_r - MOD_CW'(1);
      done_nxt = (cnt_r == MOD_CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    div_r <= div_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

`default_nettype wire

@@ hw/rtl/cartridge_mapper_irq_wave_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Direction | Ports
// ---------+-----------+-----------------------------------------------------
// in       | input     | in_valid, in_stall, in_func, in_address, in_data
// out      | output    | out_valid, out_stall, out_read_data, out_irq_fire,
//          |           | out_map_kind, out_map_slot, out_map_page,
//          |           | out_map_internal
// cfg      | input     | cfg_we, cfg_index, cfg_data
//
// Every transaction yields one result via states EXEC and DONE, plus RAMRD for
// internal RAM read (registered RAM port) and DIV for a nametable page below
// 0xE0 with a nonzero CHR page count, reduced by the bit-serial remainder unit
// at one bit per cycle. Synchronous active-low reset clears control state and
// marks every RAM byte as zero. While a result stalls in the output register,
// one more transaction can be taken; it waits in the done state until then.

module cartridge_mapper_irq_wave_ram
  import cmirq_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [1:0]            in_func,
  input  wire logic [15:0]           in_address,
  input  wire logic [7:0]            in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [7:0]                 out_read_data,
  output logic                       out_irq_fire,
  output logic [1:0]                 out_map_kind,
  output logic [2:0]                 out_map_slot,
  output logic [7:0]                 out_map_page,
  output logic                       out_map_internal,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EXEC  = 5'b00010,
    S_RAMRD = 5'b00100,
    S_DIV   = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t      state_r, state_nxt;
  logic [1:0]  func_r;
  logic [15:0] addr_r;
  logic [7:0]  data_r;
  logic [8:0]  chr_cnt_r;
  logic [9:0]  tick_inc_r;
  logic [7:0]  ptr_r, ptr_nxt;
  logic [14:0] cnt_r, cnt_nxt;
  logic [14:0] latch_r, latch_nxt;
  logic        irq_en_r, irq_en_nxt;
  result_t     res_r, res_nxt;
  result_t     out_res_r;
  logic        out_valid_r, out_valid_nxt;
  logic        out_load;
  logic [4:0]  reg_sel;
  logic [15:0] tick_sum;
  logic [7:0]  ptr_step;
  ram_req_t    ram_req;
  logic [7:0]  ram_rdata;
  mod_req_t    mod_req;
  mod_rsp_t    mod_rsp;

  cmirq_ram u_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  cmirq_mod u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req),
    .rsp   (mod_rsp)
  );

  assign reg_sel  = addr_r[15:11];
  assign tick_sum = {1'b0, cnt_r} + {6'd0, tick_inc_r};
  assign ptr_step = ptr_r[7] ? {1'b1, 7'(ptr_r[6:0] + 7'd1)} : ptr_r;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt  = state_r;
    ptr_nxt    = ptr_r;
    cnt_nxt    = cnt_r;
    latch_nxt  = latch_r;
    irq_en_nxt = irq_en_r;
    res_nxt    = res_r;
    ram_req    = '{we: 1'b0, re: 1'b0, addr: ptr_r[RAM_AW-1:0], wdata: data_r};
    mod_req    = '{start: 1'b0, dividend: data_r, divisor: chr_cnt_r};
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        res_nxt   = '0;
        state_nxt = S_DONE;
        case (func_r)
          FUNC_READ: begin
            case (reg_sel) inside
              REG_RAM: begin
                ram_req.re = 1'b1;
                ptr_nxt    = ptr_step;
                state_nxt  = S_RAMRD;
              end
              REG_CNT_LO: res_nxt.read_data = cnt_r[7:0];
              REG_CNT_HI: res_nxt.read_data = {1'b0, cnt_r[14:8]};
              default: ;
            endcase
          end
          FUNC_WRITE: begin
            case (reg_sel) inside
              REG_RAM: begin
                ram_req.we = 1'b1;
                ptr_nxt    = ptr_step;
              end
              REG_CNT_LO: begin
                latch_nxt = {latch_r[14:8], data_r};
                cnt_nxt   = latch_nxt;
              end
              REG_CNT_HI: begin
                latch_nxt  = {data_r[6:0], latch_r[7:0]};
                irq_en_nxt = data_r[7];
                cnt_nxt    = latch_nxt;
              end
              [REG_PAT_LO:REG_PAT_HI]: begin
                res_nxt.map_kind = MAP_PATTERN;
                res_nxt.map_slot = reg_sel[2:0];
                res_nxt.map_page = data_r;
              end
              [REG_NT_LO:REG_NT_HI]: begin
                res_nxt.map_kind = MAP_NAME;
                res_nxt.map_slot = {1'b0, reg_sel[1:0]};
                if (data_r >= NT_INTERNAL_MIN) begin
                  res_nxt.map_internal = 1'b1;
                  res_nxt.map_page     = {6'd0, data_r[1:0]};
                end else if (chr_cnt_r == 9'd0) begin
                  res_nxt.map_page = data_r;
                end else begin
                  mod_req.start = 1'b1;
                  state_nxt     = S_DIV;
                end
              end
              [REG_PRG_LO:REG_PRG_HI]: begin
                res_nxt.map_kind = MAP_PROGRAM;
                res_nxt.map_slot = 3'(reg_sel[2:0] - PRG_SLOT_OFS);
                res_nxt.map_page = data_r;
              end
              REG_POINTER: ptr_nxt = data_r;
              default: ;
            endcase
          end
          FUNC_TICK: begin
            if (irq_en_r) begin
              if (tick_sum >= IRQ_LIMIT) begin
                cnt_nxt          = IRQ_LIMIT[14:0];
                irq_en_nxt       = 1'b0;
                res_nxt.irq_fire = 1'b1;
              end else begin
                cnt_nxt = tick_sum[14:0];
              end
            end
          end
          default: ;
        endcase
      end
      S_RAMRD: begin
        res_nxt.read_data = ram_rdata;
        state_nxt         = S_DONE;
      end
      S_DIV: begin
        if (mod_rsp.done) begin
          res_nxt.map_page = mod_rsp.rem;
          state_nxt        = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ptr_r       <= 8'd0;
      cnt_r       <= 15'd0;
      latch_r     <= 15'd0;
      irq_en_r    <= 1'b0;
      out_valid_r <= 1'b0;
      chr_cnt_r   <= CHR_PAGE_COUNT_RST;
      tick_inc_r  <= TICK_INCREMENT_RST;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      cnt_r       <= cnt_nxt;
      latch_r     <= latch_nxt;
      irq_en_r    <= irq_en_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && cfg_index == CFG_CHR_PAGE_COUNT) begin
        chr_cnt_r <= cfg_data[8:0];
      end
      if (cfg_we && cfg_index == CFG_TICK_INCREMENT) begin
        tick_inc_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (state_r == S_IDLE && in_valid) begin
      func_r <= in_func;
      addr_r <= in_address;
      data_r <= in_data;
    end
    if (out_load) begin
      out_res_r <= res_r;
    end
  end

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_read_data    = out_res_r.read_data;
  assign out_irq_fire     = out_res_r.irq_fire;
  assign out_map_kind     = out_res_r.map_kind;
  assign out_map_slot     = out_res_r.map_slot;
  assign out_map_page     = out_res_r.map_page;
  assign out_map_internal = out_res_r.map_internal;

  a_fire_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_irq_fire |-> out_map_kind == MAP_NONE && out_read_data == 8'd0)
    else $error("IRQ result carries other fields");

  a_internal_nt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_map_internal |-> out_map_kind == MAP_NAME)
    else $error("internal page flag outside a nametable update");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    mod_rsp.done |-> state_r == S_DIV)
    else $error("remainder finished outside the divide state");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second transaction accepted while busy");

  a_counter_limit: assert property (@(posedge clk) disable iff (!rst_n)
    res_r.irq_fire && state_r == S_DONE |-> cnt_r == IRQ_LIMIT[14:0] && !irq_en_r)
    else $error("IRQ fired without saturating the counter");

endmodule

`default_nettype wire
